@@ rtl/core/fctm_pkg.sv @@
`timescale 1ns / 1ps

package fctm_pkg;

	localparam int TEX_LOG_MAX    = 6;
	localparam int MAX_SCREEN_DIM = 1024;
	localparam int FRAC_BITS      = 16;

	// Texel index inside one texture, and the store address with the surface on top.
	localparam int TEX_IDX_W  = 2 * TEX_LOG_MAX;
	localparam int TEX_AREA   = 1 << TEX_IDX_W;
	localparam int TEX_ADDR_W = TEX_IDX_W + 1;
	localparam int TEX_DEPTH  = 2 * TEX_AREA;
	localparam int LOG_W      = $clog2(TEX_LOG_MAX + 1);

	localparam int TEXEL_W    = 16;
	localparam int COORD_W    = 32;
	localparam int ROW_W      = 10;
	localparam int DIM_W      = 11;
	localparam int PIX_ADDR_W = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	typedef enum logic [1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_ROW   = 2'd1,
		FUNC_PIXEL = 2'd2
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FLOOR_LOG   = 2'd0,
		REG_CEILING_LOG = 2'd1,
		REG_SCREEN_W    = 2'd2,
		REG_SCREEN_H    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]                func;
		logic                      surface;
		logic [11:0]               texel_index;
		logic [TEXEL_W-1:0]        texel_value;
		logic signed [COORD_W-1:0] start_u;
		logic signed [COORD_W-1:0] start_v;
		logic signed [COORD_W-1:0] step_u;
		logic signed [COORD_W-1:0] step_v;
		logic [ROW_W-1:0]          floor_row;
		logic [DIM_W-1:0]          column_limit;
	} in_item_t;

	typedef struct packed {
		logic [PIX_ADDR_W-1:0] pixel_address;
		logic [TEXEL_W-1:0]    color;
	} out_item_t;

endpackage

@@ rtl/core/fctm_ram.sv @@
`timescale 1ns / 1ps

module fctm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/floor_ceiling_texture_mapper_top.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_data  (fctm_pkg::in_item_t)
// out       output     out_valid / out_ready  out_data (fctm_pkg::out_item_t)
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// One item is taken every cycle while in_ready is high. A pixel that hits a texel passes
// through the texture memory read stage and then the output register on its way out.
// Loads, begin-row items and pixels that miss produce nothing and free the slot at once.
// Reset clears the valid flags and accumulators and sets the configuration registers to their
// defaults; the data registers and the texture memory are not cleared. A stalled output holds
// one result in the output register and one in the read stage; in_ready falls only when both are full.

module floor_ceiling_texture_mapper_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  fctm_pkg::in_item_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output fctm_pkg::out_item_t                  out_data,
	input  logic                                 cfg_we,
	input  logic [fctm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fctm_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic [2:0]                         floor_log_q;
	logic [2:0]                         ceiling_log_q;
	logic [fctm_pkg::DIM_W-1:0]         screen_w_q;
	logic [fctm_pkg::DIM_W-1:0]         screen_h_q;

	logic [fctm_pkg::COORD_W-1:0]       coord_u_q;
	logic [fctm_pkg::COORD_W-1:0]       coord_v_q;
	logic [fctm_pkg::COORD_W-1:0]       incr_u_q;
	logic [fctm_pkg::COORD_W-1:0]       incr_v_q;
	logic [fctm_pkg::DIM_W-1:0]         column_q;
	logic [fctm_pkg::ROW_W-1:0]         row_q;
	logic                               surface_q;

	logic                               valid_s1;
	logic [fctm_pkg::PIX_ADDR_W-1:0]    addr_s1;
	logic                               valid_s2;
	logic [fctm_pkg::PIX_ADDR_W-1:0]    addr_s2;
	logic [fctm_pkg::TEXEL_W-1:0]       color_s2;

	logic                               accept;
	logic                               is_load;
	logic                               is_row;
	logic                               is_pixel;
	logic                               move_s1;
	logic [fctm_pkg::DIM_W-1:0]         width_cl;
	logic [fctm_pkg::DIM_W-1:0]         height_cl;
	logic [fctm_pkg::DIM_W-1:0]         row_ext;
	logic [fctm_pkg::DIM_W-1:0]         mirror_row;
	logic [fctm_pkg::DIM_W-1:0]         screen_row;
	logic                               row_on_screen;
	logic                               hit;
	logic                               in_width;
	logic                               emit;
	logic [2*fctm_pkg::DIM_W-1:0]       row_base;
	logic [2*fctm_pkg::DIM_W-1:0]       pix_addr_full;
	logic [fctm_pkg::LOG_W-1:0]         tex_log;
	logic [15:0]                        u_shift;
	logic [15:0]                        v_shift;
	logic [15:0]                        tex_mask;
	logic [fctm_pkg::TEX_LOG_MAX-1:0]   tex_x;
	logic [fctm_pkg::TEX_LOG_MAX-1:0]   tex_y;
	logic [fctm_pkg::TEX_IDX_W-1:0]     tex_idx;
	logic [fctm_pkg::TEX_ADDR_W-1:0]    rd_addr;
	logic [fctm_pkg::TEX_ADDR_W-1:0]    wr_addr;
	logic [fctm_pkg::TEXEL_W-1:0]       rd_data;

	function automatic logic [fctm_pkg::LOG_W-1:0] clamp_log(input logic [2:0] v);
		if (int'(v) > fctm_pkg::TEX_LOG_MAX) begin
			return fctm_pkg::LOG_W'(fctm_pkg::TEX_LOG_MAX);
		end
		return fctm_pkg::LOG_W'(v);
	endfunction

	function automatic logic [fctm_pkg::DIM_W-1:0] clamp_dim(
		input logic [fctm_pkg::DIM_W-1:0] v
	);
		if (int'(v) > fctm_pkg::MAX_SCREEN_DIM) begin
			return fctm_pkg::DIM_W'(fctm_pkg::MAX_SCREEN_DIM);
		end
		return v;
	endfunction

	// The read stage drains when the output register is empty or being emptied.
	assign move_s1  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || move_s1;
	assign accept   = in_valid && in_ready;
	assign is_load  = accept && (in_data.func == fctm_pkg::FUNC_LOAD);
	assign is_row   = accept && (in_data.func == fctm_pkg::FUNC_ROW);
	assign is_pixel = accept && (in_data.func == fctm_pkg::FUNC_PIXEL);

	always_comb begin
		width_cl      = clamp_dim(screen_w_q);
		height_cl     = clamp_dim(screen_h_q);
		row_ext       = fctm_pkg::DIM_W'(row_q);
		row_on_screen = row_ext < height_cl;
		mirror_row    = height_cl - fctm_pkg::DIM_W'(1) - row_ext;
		if (surface_q) begin
			screen_row = mirror_row;
			hit        = row_on_screen && (mirror_row < in_data.column_limit);
			tex_log    = clamp_log(ceiling_log_q);
		end else begin
			screen_row = row_ext;
			hit        = row_on_screen && (row_ext >= in_data.column_limit);
			tex_log    = clamp_log(floor_log_q);
		end
		in_width      = column_q < width_cl;
		emit          = is_pixel && in_width && hit;
		row_base      = screen_row * width_cl;
		pix_addr_full = row_base + (2*fctm_pkg::DIM_W)'(column_q);

		// Only the low 16 bits of each coordinate reach the index, and they are shifted
		// logically, so the sign of the coordinate never matters.
		u_shift  = coord_u_q[15:0] >> (5'(fctm_pkg::FRAC_BITS) - 5'(tex_log));
		v_shift  = coord_v_q[15:0] >> (5'(fctm_pkg::FRAC_BITS) - 5'(tex_log));
		tex_mask = (16'd1 << tex_log) - 16'd1;
		tex_x    = fctm_pkg::TEX_LOG_MAX'(u_shift & tex_mask);
		tex_y    = fctm_pkg::TEX_LOG_MAX'(v_shift & tex_mask);
		tex_idx  = (fctm_pkg::TEX_IDX_W'(tex_y) << tex_log) + fctm_pkg::TEX_IDX_W'(tex_x);
		rd_addr  = {surface_q, tex_idx};
		wr_addr  = {in_data.surface, fctm_pkg::TEX_IDX_W'(in_data.texel_index)};
	end

	fctm_ram #(
		.WIDTH(fctm_pkg::TEXEL_W),
		.DEPTH(fctm_pkg::TEX_DEPTH)
	) u_texture (
		.clk  (clk),
		.we   (is_load),
		.waddr(wr_addr),
		.wdata(in_data.texel_value),
		.re   (emit),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_log_q   <= 3'd6;
			ceiling_log_q <= 3'd6;
			screen_w_q    <= fctm_pkg::DIM_W'(320);
			screen_h_q    <= fctm_pkg::DIM_W'(200);
		end else if (cfg_we) begin
			unique case (cfg_index)
				fctm_pkg::REG_FLOOR_LOG:   floor_log_q   <= cfg_data[2:0];
				fctm_pkg::REG_CEILING_LOG: ceiling_log_q <= cfg_data[2:0];
				fctm_pkg::REG_SCREEN_W:    screen_w_q    <= cfg_data;
				fctm_pkg::REG_SCREEN_H:    screen_h_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_u_q <= '0;
			coord_v_q <= '0;
			incr_u_q  <= '0;
			incr_v_q  <= '0;
			column_q  <= '0;
			row_q     <= '0;
			surface_q <= 1'b0;
		end else if (is_row) begin
			coord_u_q <= in_data.start_u;
			coord_v_q <= in_data.start_v;
			incr_u_q  <= in_data.step_u;
			incr_v_q  <= in_data.step_v;
			column_q  <= '0;
			row_q     <= in_data.floor_row;
			surface_q <= in_data.surface;
		end else if (is_pixel && in_width) begin
			// Pixels past the screen width leave the span untouched.
			coord_u_q <= coord_u_q + incr_u_q;
			coord_v_q <= coord_v_q + incr_v_q;
			column_q  <= column_q + fctm_pkg::DIM_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= emit;
			end
			if (move_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			addr_s1 <= pix_addr_full[fctm_pkg::PIX_ADDR_W-1:0];
		end
		if (move_s1 && valid_s1) begin
			addr_s2  <= addr_s1;
			color_s2 <= rd_data;
		end
	end

	assign out_valid              = valid_s2;
	assign out_data.pixel_address = addr_s2;
	assign out_data.color         = color_s2;

endmodule

@@ rtl/core/fctm_checker.sv @@
`timescale 1ns / 1ps

module fctm_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input fctm_pkg::in_item_t                   in_data,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input fctm_pkg::out_item_t                  out_data
);

	// A result stays offered until its transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before its transfer");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("stalled result changed");

	// Input back-pressure only comes from a stalled, full output side.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while the output can move");

	// A fresh result follows a pixel transfer through the read stage and the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |->
			$past(in_valid && in_ready && (in_data.func == fctm_pkg::FUNC_PIXEL), 2))
		else $error("result without a matching pixel transfer");

endmodule

bind floor_ceiling_texture_mapper_top fctm_checker u_fctm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.in_data  (in_data),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);
